/* rtl/dbtog_pkg.sv */
// Shared types, codes and constants for the debounced toggle block.
package dbtog_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;

    localparam int DEBOUNCE_W = 16;
    localparam int COOLDOWN_W = 16;
    localparam int TIMEOUT_W  = 11;
    localparam int INTERVAL_W = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    localparam int MS_W      = 32;
    localparam int EPOCH_W   = 32;
    localparam int SECONDS_W = 32;
    localparam int TOUT_S_W  = 17;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    // Input tdata layout
    localparam int IN_BTN_LSB   = 0;
    localparam int IN_NOW_LSB   = 1;
    localparam int IN_EPOCH_LSB = 33;
    localparam int IN_WAKE_LSB  = 65;
    localparam int IN_SET_LSB   = 66;

    // Output tdata layout
    localparam int OUT_MODE_LSB    = 0;
    localparam int OUT_TOGGLED_LSB = 1;
    localparam int OUT_TIMEOUT_LSB = 2;
    localparam int OUT_START_LSB   = 3;
    localparam int OUT_ELAPSED_LSB = 35;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST = 16'd1000;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 11'd60;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 17'd600;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_DEFAULT_MIN = 11'd60;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX_MIN     = 11'd1440;
    localparam logic [TOUT_S_W-1:0]  SECONDS_PER_MIN     = 17'd60;

    typedef enum logic [1:0] {
        REQ_BUTTON  = 2'd0,
        REQ_WAKE    = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_SET     = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_COOLDOWN = 2'd1,
        CFG_TIMEOUT  = 2'd2,
        CFG_INTERVAL = 2'd3
    } cfg_idx_t;

endpackage

/* rtl/debounced_toggle_with_auto_timeout_top.sv */
// Debounced button toggle with wake aging and automatic timeout, top level.
//
// Input channel s_axis_*: one transfer per request; tuser carries the request
// kind (button sample, wake, timeout check, set command), tdata the button
// level, millisecond time, epoch seconds, wake cause and set value.
// Output channel m_axis_*: exactly one result transfer per request, in order.
// Configuration: cfg_wen writes cfg_data into register cfg_idx at the clock
// edge; write only while no request is in flight.
// Path: each request passes the input register, then the result register.
// Throughput: one request per cycle while the output is not stalled; the
// whole update is one pass of logic between the input and result registers.
// Stall: when m_axis_tready is low the result register holds; the input
// register still takes one more request, then s_axis_tready drops.
// Reset: rst_n clears the mode and all debounce state, sets the armed flag
// and loads the register defaults (50 ms, 1000 ms, 60 min, 600 s).
// TIME_WIDTH sets the width of the stored millisecond stamps; time
// differences wrap modulo 2^TIME_WIDTH.
module debounced_toggle_with_auto_timeout_top #(
    parameter int TIME_WIDTH = dbtog_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [dbtog_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [dbtog_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // button_down, now_ms, epoch_now, wake_on_button, set_on, zero fill
    input  logic [dbtog_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // mode_active, toggled, timed_out, started_epoch, elapsed_s, zero fill
    output logic [dbtog_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dbtog_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [COOLDOWN_W-1:0] cooldown_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    logic                   in_valid_reg;
    req_t                   req_reg;
    logic                   btn_reg;
    logic [MS_W-1:0]        now_reg;
    logic [EPOCH_W-1:0]     epoch_reg;
    logic                   wake_btn_reg;
    logic                   set_on_reg;

    logic                   mode_reg, mode_next;
    logic [EPOCH_W-1:0]     start_reg, start_next;
    logic [SECONDS_W-1:0]   fallback_reg, fallback_next;
    logic                   was_pressed_reg, was_pressed_next;
    logic [TIME_WIDTH-1:0]  press_start_reg, press_start_next;
    logic [TIME_WIDTH-1:0]  last_toggle_reg, last_toggle_next;
    logic                   armed_reg, armed_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                   fire;
    logic                   toggled;
    logic                   timed_out;
    logic [63:0]            now_wide;
    logic [TIME_WIDTH-1:0]  now_t;
    logic [TIME_WIDTH-1:0]  since_press;
    logic [TIME_WIDTH-1:0]  since_last;
    logic [SECONDS_W-1:0]   aged;
    logic [SECONDS_W-1:0]   elapsed;
    logic [TIMEOUT_W-1:0]   tmo_min;
    logic [TOUT_S_W-1:0]    tmo_s;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            cooldown_reg <= COOLDOWN_RST;
            timeout_reg  <= TIMEOUT_RST;
            interval_reg <= INTERVAL_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_DEBOUNCE: debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                CFG_COOLDOWN: cooldown_reg <= cfg_data[COOLDOWN_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[TIMEOUT_W-1:0];
                CFG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg      <= req_t'(s_axis_tuser);
            btn_reg      <= s_axis_tdata[IN_BTN_LSB];
            now_reg      <= s_axis_tdata[IN_NOW_LSB +: MS_W];
            epoch_reg    <= s_axis_tdata[IN_EPOCH_LSB +: EPOCH_W];
            wake_btn_reg <= s_axis_tdata[IN_WAKE_LSB];
            set_on_reg   <= s_axis_tdata[IN_SET_LSB];
        end
    end

    assign now_wide    = {32'd0, now_reg};
    assign now_t       = now_wide[TIME_WIDTH-1:0];
    assign since_press = now_t - press_start_reg;
    assign since_last  = now_t - last_toggle_reg;
    assign aged        = fallback_reg + SECONDS_W'(interval_reg);

    always_comb
    begin
        if (epoch_reg != '0 && start_reg != '0 && epoch_reg > start_reg)
            elapsed = epoch_reg - start_reg;
        else
            elapsed = fallback_reg;
    end

    always_comb
    begin
        priority if (timeout_reg == '0)
            tmo_min = TIMEOUT_DEFAULT_MIN;
        else if (timeout_reg > TIMEOUT_MAX_MIN)
            tmo_min = TIMEOUT_MAX_MIN;
        else
            tmo_min = timeout_reg;
    end

    assign tmo_s = TOUT_S_W'(tmo_min) * SECONDS_PER_MIN;

    always_comb
    begin
        mode_next        = mode_reg;
        start_next       = start_reg;
        fallback_next    = fallback_reg;
        was_pressed_next = was_pressed_reg;
        press_start_next = press_start_reg;
        last_toggle_next = last_toggle_reg;
        armed_next       = armed_reg;
        toggled          = 1'b0;
        timed_out        = 1'b0;
        unique case (req_reg)
            REQ_BUTTON:
            begin
                if (!btn_reg)
                begin
                    was_pressed_next = 1'b0;
                    armed_next       = 1'b1;
                end
                else if (!was_pressed_reg)
                begin
                    was_pressed_next = 1'b1;
                    press_start_next = now_t;
                end
                else if (armed_reg
                         && since_press >= TIME_WIDTH'(debounce_reg)
                         && !(last_toggle_reg != '0
                              && since_last < TIME_WIDTH'(cooldown_reg)))
                begin
                    armed_next       = 1'b0;
                    last_toggle_next = now_t;
                    mode_next        = !mode_reg;
                    start_next       = mode_reg ? '0 : epoch_reg;
                    fallback_next    = '0;
                    toggled          = 1'b1;
                end
            end
            REQ_WAKE:
            begin
                if (mode_reg)
                begin
                    fallback_next = aged;
                    if (start_reg == '0 && epoch_reg != '0 && epoch_reg > aged)
                        start_next = epoch_reg - aged;
                end
                if (wake_btn_reg)
                begin
                    mode_next        = !mode_reg;
                    start_next       = mode_reg ? '0 : epoch_reg;
                    fallback_next    = '0;
                    toggled          = 1'b1;
                    last_toggle_next = now_t;
                    was_pressed_next = btn_reg;
                    press_start_next = now_t;
                    armed_next       = 1'b0;
                end
            end
            REQ_TIMEOUT:
            begin
                if (mode_reg && elapsed >= SECONDS_W'(tmo_s))
                begin
                    mode_next     = 1'b0;
                    start_next    = '0;
                    fallback_next = '0;
                    toggled       = 1'b1;
                    timed_out     = 1'b1;
                end
            end
            REQ_SET:
            begin
                if (set_on_reg != mode_reg)
                begin
                    mode_next     = set_on_reg;
                    start_next    = set_on_reg ? epoch_reg : '0;
                    fallback_next = '0;
                    toggled       = 1'b1;
                end
            end
            default:
            begin
                toggled = 1'b0;
            end
        endcase
    end

    // Advance block state on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            start_reg       <= '0;
            fallback_reg    <= '0;
            was_pressed_reg <= 1'b0;
            press_start_reg <= '0;
            last_toggle_reg <= '0;
            armed_reg       <= 1'b1;
        end
        else if (fire)
        begin
            mode_reg        <= mode_next;
            start_reg       <= start_next;
            fallback_reg    <= fallback_next;
            was_pressed_reg <= was_pressed_next;
            press_start_reg <= press_start_next;
            last_toggle_reg <= last_toggle_next;
            armed_reg       <= armed_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {5'd0, fallback_next, (mode_next ? start_next : 32'd0),
                             timed_out, toggled, mode_next};
        end
    end

endmodule

/* rtl/dbtog_chk.sv */
// Port-level checker for the debounced toggle block, bound to the top level.
module dbtog_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_wen,
    input logic [dbtog_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input logic [dbtog_pkg::CFG_DATA_W-1:0]  cfg_data,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [dbtog_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [1:0]                        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dbtog_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import dbtog_pkg::*;

    logic cfg_seen;
    assign cfg_seen = cfg_wen && (cfg_idx != '0 || cfg_data != '0 || s_axis_tdata != '0
                                  || s_axis_tuser != '0 || 1'b1);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("no result two cycles after input transfer");

    a_timeout_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_TIMEOUT_LSB] |->
            !m_axis_tdata[OUT_MODE_LSB] && m_axis_tdata[OUT_TOGGLED_LSB])
        else $error("timeout without ending the mode");

    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_MODE_LSB] && !cfg_seen |->
            m_axis_tdata[OUT_START_LSB +: EPOCH_W] == '0
            && m_axis_tdata[OUT_ELAPSED_LSB +: SECONDS_W] == '0)
        else $error("inactive mode reports a start time or elapsed count");

endmodule

bind debounced_toggle_with_auto_timeout_top dbtog_chk u_dbtog_chk (.*);
